>>> rtl/aou_pkg.sv
package aou_pkg;

    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

    localparam logic [2:0]  MODE_RESET       = 3'd0;
    localparam logic [31:0] BETA_ONE_RESET   = 32'h3F66_6666;
    localparam logic [31:0] BETA_TWO_RESET   = 32'h3F7F_BE77;
    localparam logic [31:0] EPSILON_RESET    = 32'h322B_CC77;
    localparam logic [31:0] DECAY_RESET      = 32'h0000_0000;
    localparam logic [31:0] STEP_RESET       = 32'h0000_0000;
    localparam logic [31:0] INV_CORR_RESET   = 32'h3F80_0000;
    localparam logic [31:0] SHRINK_RESET     = 32'h3F80_0000;

    localparam int MODE_AMSGRAD   = 0;
    localparam int MODE_MAXIMIZE  = 1;
    localparam int MODE_DECOUPLED = 2;

    localparam int SQRT_STAGES = 13;
    localparam int DIV_STAGES  = 9;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_BETA_ONE = 3'd1,
        REG_BETA_TWO = 3'd2,
        REG_EPSILON  = 3'd3,
        REG_DECAY    = 3'd4,
        REG_STEP     = 3'd5,
        REG_INV_CORR = 3'd6,
        REG_SHRINK   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] w;
        logic [31:0] m;
        logic [31:0] v;
        logic [31:0] peak;
    } carry_t;

    localparam int CARRY_W = $bits(carry_t);

    typedef struct packed {
        logic signed [11:0] e;
        logic [23:0]        m;
    } norm_t;

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic [31:0] fp_canon(input logic [31:0] x);
        return is_nan(x) ? QNAN : x;
    endfunction

    // mantissa with leading one at bit 23, biased-style exponent (may go below 1)
    function automatic norm_t fp_norm(input logic [31:0] x);
        norm_t      r;
        logic [23:0] m;
        logic [4:0]  lz;
        m  = (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
        lz = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (m[i])
                lz = 5'(23 - i);
        end
        r.m = m << lz;
        r.e = ((x[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, x[30:23]}))
              - $signed({7'b0, lz});
        return r;
    endfunction

    // m: leading one at bit 26, bits 2..0 guard and sticky; e biased
    function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] e,
                                             input logic [26:0] m);
        logic [11:0]        sh;
        logic signed [11:0] e1;
        logic [26:0]        ms;
        logic               lost;
        logic               rnd;
        logic [24:0]        mr;
        logic [23:0]        mant;
        if (e >= 12'sd1)
        begin
            sh = 12'd0;
            e1 = e;
        end
        else
        begin
            sh = 12'(12'sd1 - e);
            e1 = 12'sd1;
        end
        if (sh > 12'd27)
        begin
            ms   = 27'd0;
            lost = |m;
        end
        else
        begin
            ms   = m >> sh;
            lost = |(m & ~(27'h7FF_FFFF << sh));
        end
        rnd = ms[2] & (ms[1] | ms[0] | lost | ms[3]);
        mr  = {1'b0, ms[26:3]} + 25'(rnd);
        if (mr[24])
        begin
            mant = mr[24:1];
            e1   = e1 + 12'sd1;
        end
        else
        begin
            mant = mr[23:0];
        end
        if (e1 >= 12'sd255)
            return {sign, 8'hFF, 23'd0};
        return {sign, mant[23] ? e1[7:0] : 8'h00, mant[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic               az;
        logic               bz;
        norm_t              na;
        norm_t              nb;
        logic [47:0]        p;
        logic [26:0]        m;
        logic signed [11:0] e;
        s  = a[31] ^ b[31];
        az = (a[30:0] == 31'd0);
        bz = (b[30:0] == 31'd0);
        na = fp_norm(a);
        nb = fp_norm(b);
        p  = na.m * nb.m;
        if (p[47])
        begin
            m = {p[47:22], |p[21:0]};
            e = na.e + nb.e - 12'sd126;
        end
        else
        begin
            m = {p[46:21], |p[20:0]};
            e = na.e + nb.e - 12'sd127;
        end
        if (is_nan(a) || is_nan(b) || (is_inf(a) && bz) || (is_inf(b) && az))
            return QNAN;
        if (is_inf(a) || is_inf(b))
            return {s, 8'hFF, 23'd0};
        if (az || bz)
            return {s, 31'd0};
        return fp_round(s, e, m);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]        x;
        logic [31:0]        y;
        logic [7:0]         ex;
        logic [7:0]         ey;
        logic [7:0]         d;
        logic [26:0]        bx;
        logic [26:0]        by;
        logic [26:0]        yw;
        logic               stk;
        logic [27:0]        sum;
        logic [27:0]        sn;
        logic [4:0]         lz;
        logic signed [11:0] e;
        if (a[30:0] < b[30:0])
        begin
            x = b;
            y = a;
        end
        else
        begin
            x = a;
            y = b;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        bx = {(x[30:23] != 8'd0), x[22:0], 3'b000};
        yw = {(y[30:23] != 8'd0), y[22:0], 3'b000};
        if (d > 8'd26)
        begin
            by  = 27'd0;
            stk = |yw;
        end
        else
        begin
            by  = yw >> d;
            stk = |(yw & ~(27'h7FF_FFFF << d));
        end
        by[0] = by[0] | stk;
        if (x[31] == y[31])
            sum = {1'b0, bx} + {1'b0, by};
        else
            sum = {1'b0, bx} - {1'b0, by};
        lz = 5'd0;
        for (int i = 0; i < 28; i++)
        begin
            if (sum[i])
                lz = 5'(27 - i);
        end
        sn = sum << lz;
        e  = $signed({4'b0, ex}) + 12'sd1 - $signed({7'b0, lz});
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31])))
            return QNAN;
        if (is_inf(a))
            return a;
        if (is_inf(b))
            return b;
        if (sum == 28'd0)
            return {x[31] & y[31], 31'd0};
        return fp_round(x[31], e, {sn[27:2], |sn[1:0]});
    endfunction

    function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a) || is_nan(b))
            return 1'b0;
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            return 1'b0;
        if (a[31] != b[31])
            return a[31];
        if (!a[31])
            return a[30:0] < b[30:0];
        return a[30:0] > b[30:0];
    endfunction

endpackage

>>> rtl/aou_sqrt.sv
module aou_sqrt #(
    parameter int SIDE_W = aou_pkg::CARRY_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [31:0]       in_x,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STAGES = aou_pkg::SQRT_STAGES;
    localparam int ROOT_W = 26;
    localparam int PER    = ROOT_W / STAGES;

    typedef struct packed {
        logic               special;
        logic [31:0]        sval;
        logic signed [11:0] hexp;
        logic [51:0]        num;
        logic [25:0]        root;
        logic [27:0]        rem;
        logic [SIDE_W-1:0]  side;
    } stage_t;

    stage_t            pipe_reg  [0:STAGES];
    stage_t            pipe_next [0:STAGES];
    logic [STAGES:0]   valid_reg;
    logic              out_valid_reg;
    logic [31:0]       out_root_reg;
    logic [SIDE_W-1:0] out_side_reg;
    logic [31:0]       root_next;

    function automatic stage_t root_step(input stage_t c);
        stage_t      r;
        logic [29:0] t;
        logic [29:0] trial;
        r     = c;
        t     = {c.rem, c.num[51:50]};
        trial = {2'b00, c.root, 2'b01};
        if (t >= trial)
        begin
            r.rem  = 28'(t - trial);
            r.root = {c.root[24:0], 1'b1};
        end
        else
        begin
            r.rem  = t[27:0];
            r.root = {c.root[24:0], 1'b0};
        end
        r.num = {c.num[49:0], 2'b00};
        return r;
    endfunction

    always_comb
    begin
        aou_pkg::norm_t     nx;
        logic [24:0]        m25;
        logic signed [11:0] e2;
        nx = aou_pkg::fp_norm(in_x);
        if (nx.e[0])
        begin
            m25 = {nx.m, 1'b0};
            e2  = nx.e - 12'sd1;
        end
        else
        begin
            m25 = {1'b0, nx.m};
            e2  = nx.e;
        end
        pipe_next[0].special = (in_x[30:23] == 8'hFF) || (in_x[30:0] == 31'd0) || in_x[31];
        if (in_x[30:23] == 8'hFF)
            pipe_next[0].sval = ((in_x[22:0] != 23'd0) || in_x[31]) ? aou_pkg::QNAN : in_x;
        else if (in_x[30:0] == 31'd0)
            pipe_next[0].sval = in_x;
        else
            pipe_next[0].sval = aou_pkg::QNAN;
        pipe_next[0].hexp = (e2 - 12'sd176) >>> 1;
        pipe_next[0].num  = {1'b0, m25, 26'd0};
        pipe_next[0].root = 26'd0;
        pipe_next[0].rem  = 28'd0;
        pipe_next[0].side = in_side;
    end

    always_comb
    begin
        stage_t cur;
        for (int s = 0; s < STAGES; s++)
        begin
            cur = pipe_reg[s];
            for (int k = 0; k < PER; k++)
                cur = root_step(cur);
            pipe_next[s + 1] = cur;
        end
    end

    always_comb
    begin
        stage_t      fin;
        logic        st;
        logic [26:0] m27;
        fin = pipe_reg[STAGES];
        st  = (fin.rem != 28'd0);
        if (fin.root[25])
            m27 = {fin.root, st};
        else
            m27 = {fin.root[24:0], st, 1'b0};
        if (fin.special)
            root_next = fin.sval;
        else if (fin.root[25])
            root_next = aou_pkg::fp_round(1'b0, fin.hexp + 12'sd152, m27);
        else
            root_next = aou_pkg::fp_round(1'b0, fin.hexp + 12'sd151, m27);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[STAGES-1:0], in_valid};
            out_valid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= STAGES; s++)
            pipe_reg[s] <= pipe_next[s];
        out_root_reg <= root_next;
        out_side_reg <= pipe_reg[STAGES].side;
    end

    assign out_valid = out_valid_reg;
    assign out_root  = out_root_reg;
    assign out_side  = out_side_reg;

endmodule

>>> rtl/aou_div.sv
module aou_div #(
    parameter int SIDE_W = aou_pkg::CARRY_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [31:0]       in_num,
    input  logic [31:0]       in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [31:0]       out_quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STAGES = aou_pkg::DIV_STAGES;
    localparam int QUO_W  = 27;
    localparam int PER    = QUO_W / STAGES;

    typedef struct packed {
        logic               special;
        logic [31:0]        sval;
        logic               sign;
        logic signed [11:0] e;
        logic [23:0]        dm;
        logic [24:0]        rem;
        logic [26:0]        quo;
        logic [SIDE_W-1:0]  side;
    } stage_t;

    stage_t            pipe_reg  [0:STAGES];
    stage_t            pipe_next [0:STAGES];
    logic [STAGES:0]   valid_reg;
    logic              out_valid_reg;
    logic [31:0]       out_quo_reg;
    logic [SIDE_W-1:0] out_side_reg;
    logic [31:0]       quo_next;

    function automatic stage_t div_step(input stage_t c);
        stage_t      r;
        logic [24:0] rr;
        r = c;
        if (c.rem >= {1'b0, c.dm})
        begin
            rr    = c.rem - {1'b0, c.dm};
            r.quo = {c.quo[25:0], 1'b1};
        end
        else
        begin
            rr    = c.rem;
            r.quo = {c.quo[25:0], 1'b0};
        end
        r.rem = {rr[23:0], 1'b0};
        return r;
    endfunction

    always_comb
    begin
        aou_pkg::norm_t nn;
        aou_pkg::norm_t nd;
        logic           s;
        logic           nz;
        logic           dz;
        logic           nnan;
        logic           dnan;
        logic           ninf;
        logic           dinf;
        nn   = aou_pkg::fp_norm(in_num);
        nd   = aou_pkg::fp_norm(in_den);
        s    = in_num[31] ^ in_den[31];
        nz   = (in_num[30:0] == 31'd0);
        dz   = (in_den[30:0] == 31'd0);
        nnan = aou_pkg::is_nan(in_num);
        dnan = aou_pkg::is_nan(in_den);
        ninf = aou_pkg::is_inf(in_num);
        dinf = aou_pkg::is_inf(in_den);
        pipe_next[0].special = 1'b1;
        if (dz)
            pipe_next[0].sval = (nnan || nz) ? aou_pkg::QNAN : {s, 8'hFF, 23'd0};
        else if (nnan || dnan || (ninf && dinf))
            pipe_next[0].sval = aou_pkg::QNAN;
        else if (ninf)
            pipe_next[0].sval = {s, 8'hFF, 23'd0};
        else if (dinf || nz)
            pipe_next[0].sval = {s, 31'd0};
        else
        begin
            pipe_next[0].sval    = aou_pkg::QNAN;
            pipe_next[0].special = 1'b0;
        end
        pipe_next[0].sign = s;
        pipe_next[0].e    = nn.e - nd.e;
        pipe_next[0].dm   = nd.m;
        pipe_next[0].rem  = {1'b0, nn.m};
        pipe_next[0].quo  = 27'd0;
        pipe_next[0].side = in_side;
    end

    always_comb
    begin
        stage_t cur;
        for (int s = 0; s < STAGES; s++)
        begin
            cur = pipe_reg[s];
            for (int k = 0; k < PER; k++)
                cur = div_step(cur);
            pipe_next[s + 1] = cur;
        end
    end

    always_comb
    begin
        stage_t fin;
        logic   st;
        fin = pipe_reg[STAGES];
        st  = (fin.rem != 25'd0);
        if (fin.special)
            quo_next = fin.sval;
        else if (fin.quo[26])
            quo_next = aou_pkg::fp_round(fin.sign, fin.e + 12'sd127,
                                         {fin.quo[26:1], fin.quo[0] | st});
        else
            quo_next = aou_pkg::fp_round(fin.sign, fin.e + 12'sd126, {fin.quo[25:0], st});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[STAGES-1:0], in_valid};
            out_valid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= STAGES; s++)
            pipe_reg[s] <= pipe_next[s];
        out_quo_reg  <= quo_next;
        out_side_reg <= pipe_reg[STAGES].side;
    end

    assign out_valid = out_valid_reg;
    assign out_quo   = out_quo_reg;
    assign out_side  = out_side_reg;

endmodule

>>> rtl/adam_optimizer_update_unit.sv
// Streaming FP32 Adam / AdamW / AMSGrad element update.
// Input channel: drive weight, gradient, first_moment, second_moment and
// peak_second_moment with start high; the word is taken at any edge where
// busy is low. busy never rises, so one word can enter every cycle.
// Result channel: done is high for exactly one cycle with new_weight,
// new_first_moment, new_second_moment and new_peak_second_moment; the
// receiver must take the word in that cycle, there is no backpressure.
// Throughput is one word per cycle. The delay from start to done is
// set by the chain of float stages, the 13-stage square root and the
// 9-stage divider.
// Configuration: write cfg_data to register cfg_index with cfg_valid;
// cfg_ready is always high. Write only while no word is in flight.
// Reset clears the pipeline valid bits and restores register defaults.
module adam_optimizer_update_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] weight,
    input  logic [31:0] gradient,
    input  logic [31:0] first_moment,
    input  logic [31:0] second_moment,
    input  logic [31:0] peak_second_moment,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [31:0] new_weight,
    output logic [31:0] new_first_moment,
    output logic [31:0] new_second_moment,
    output logic [31:0] new_peak_second_moment
);

    localparam int SQ_SIDE_W = aou_pkg::CARRY_W + 32;

    logic [2:0]  mode_reg;
    logic [31:0] beta_one_reg;
    logic [31:0] beta_two_reg;
    logic [31:0] epsilon_reg;
    logic [31:0] decay_reg;
    logic [31:0] step_reg;
    logic [31:0] inv_corr_reg;
    logic [31:0] shrink_reg;
    logic [31:0] ob1_reg;
    logic [31:0] ob2_reg;

    logic amsgrad;
    logic decay_on;
    logic decoupled;

    logic        s1_valid_reg;
    logic [31:0] s1_w_reg, s1_g_reg, s1_td_reg, s1_bm_reg, s1_bv_reg, s1_peak_reg;
    logic        s2_valid_reg;
    logic [31:0] s2_w_reg, s2_g_reg, s2_bm_reg, s2_bv_reg, s2_peak_reg;
    logic        s3_valid_reg;
    logic [31:0] s3_w_reg, s3_g_reg, s3_bm_reg, s3_bv_reg, s3_peak_reg, s3_u1_reg, s3_u2_reg;
    logic        s4_valid_reg;
    logic [31:0] s4_w_reg, s4_m_reg, s4_bv_reg, s4_u3_reg, s4_peak_reg;
    logic        s5_valid_reg;
    logic [31:0] s5_w_reg, s5_m_reg, s5_v_reg, s5_ts_reg, s5_peak_reg;
    logic        s6_valid_reg;
    logic [31:0] s6_scaled_reg;
    logic [SQ_SIDE_W-1:0] s6_side_reg;

    logic                 sq_valid;
    logic [31:0]          sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;

    logic                  ep_valid_reg;
    logic [31:0]           ep_den_reg;
    logic [31:0]           ep_num_reg;
    aou_pkg::carry_t       ep_carry_reg;

    logic                  dv_valid;
    logic [31:0]           dv_quo;
    logic [aou_pkg::CARRY_W-1:0] dv_side;
    aou_pkg::carry_t       dv_carry;

    logic        out_valid_reg;
    logic [31:0] out_w_reg, out_m_reg, out_v_reg, out_peak_reg;

    logic [31:0]     peak_max;
    aou_pkg::carry_t s6_carry;

    assign amsgrad   = mode_reg[aou_pkg::MODE_AMSGRAD];
    assign decoupled = mode_reg[aou_pkg::MODE_DECOUPLED];
    assign decay_on  = (decay_reg[30:0] != 31'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= aou_pkg::MODE_RESET;
            beta_one_reg <= aou_pkg::BETA_ONE_RESET;
            beta_two_reg <= aou_pkg::BETA_TWO_RESET;
            epsilon_reg  <= aou_pkg::EPSILON_RESET;
            decay_reg    <= aou_pkg::DECAY_RESET;
            step_reg     <= aou_pkg::STEP_RESET;
            inv_corr_reg <= aou_pkg::INV_CORR_RESET;
            shrink_reg   <= aou_pkg::SHRINK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (aou_pkg::cfg_reg_t'(cfg_index))
                aou_pkg::REG_MODE:     mode_reg     <= cfg_data[2:0];
                aou_pkg::REG_BETA_ONE: beta_one_reg <= cfg_data;
                aou_pkg::REG_BETA_TWO: beta_two_reg <= cfg_data;
                aou_pkg::REG_EPSILON:  epsilon_reg  <= cfg_data;
                aou_pkg::REG_DECAY:    decay_reg    <= cfg_data;
                aou_pkg::REG_STEP:     step_reg     <= cfg_data;
                aou_pkg::REG_INV_CORR: inv_corr_reg <= cfg_data;
                aou_pkg::REG_SHRINK:   shrink_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // one minus beta, refreshed every cycle from the registers
    always_ff @(posedge clk)
    begin
        ob1_reg <= aou_pkg::fp_add(aou_pkg::ONE_BITS, {~beta_one_reg[31], beta_one_reg[30:0]});
        ob2_reg <= aou_pkg::fp_add(aou_pkg::ONE_BITS, {~beta_two_reg[31], beta_two_reg[30:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            ep_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= start && !busy;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            ep_valid_reg  <= sq_valid;
            out_valid_reg <= dv_valid;
        end
    end

    assign peak_max = aou_pkg::fp_lt(s5_peak_reg, s5_v_reg) ? s5_v_reg : s5_peak_reg;

    always_comb
    begin
        s6_carry.w    = s5_w_reg;
        s6_carry.m    = s5_m_reg;
        s6_carry.v    = s5_v_reg;
        s6_carry.peak = amsgrad ? aou_pkg::fp_canon(peak_max) : s5_peak_reg;
    end

    always_ff @(posedge clk)
    begin
        // decay terms and beta products
        s1_w_reg    <= (decay_on && decoupled) ? aou_pkg::fp_mul(weight, shrink_reg) : weight;
        s1_g_reg    <= {gradient[31] ^ mode_reg[aou_pkg::MODE_MAXIMIZE], gradient[30:0]};
        s1_td_reg   <= aou_pkg::fp_mul(decay_reg, weight);
        s1_bm_reg   <= aou_pkg::fp_mul(beta_one_reg, first_moment);
        s1_bv_reg   <= aou_pkg::fp_mul(beta_two_reg, second_moment);
        s1_peak_reg <= peak_second_moment;

        s2_w_reg    <= s1_w_reg;
        s2_g_reg    <= (decay_on && !decoupled) ? aou_pkg::fp_add(s1_g_reg, s1_td_reg)
                                                : s1_g_reg;
        s2_bm_reg   <= s1_bm_reg;
        s2_bv_reg   <= s1_bv_reg;
        s2_peak_reg <= s1_peak_reg;

        s3_w_reg    <= s2_w_reg;
        s3_g_reg    <= s2_g_reg;
        s3_bm_reg   <= s2_bm_reg;
        s3_bv_reg   <= s2_bv_reg;
        s3_peak_reg <= s2_peak_reg;
        s3_u1_reg   <= aou_pkg::fp_mul(ob1_reg, s2_g_reg);
        s3_u2_reg   <= aou_pkg::fp_mul(ob2_reg, s2_g_reg);

        s4_w_reg    <= s3_w_reg;
        s4_m_reg    <= aou_pkg::fp_add(s3_bm_reg, s3_u1_reg);
        s4_bv_reg   <= s3_bv_reg;
        s4_u3_reg   <= aou_pkg::fp_mul(s3_u2_reg, s3_g_reg);
        s4_peak_reg <= s3_peak_reg;

        s5_w_reg    <= s4_w_reg;
        s5_m_reg    <= s4_m_reg;
        s5_v_reg    <= aou_pkg::fp_add(s4_bv_reg, s4_u3_reg);
        s5_ts_reg   <= aou_pkg::fp_mul(step_reg, s4_m_reg);
        s5_peak_reg <= s4_peak_reg;

        s6_scaled_reg <= aou_pkg::fp_mul(amsgrad ? peak_max : s5_v_reg, inv_corr_reg);
        s6_side_reg   <= {s6_carry, s5_ts_reg};

        ep_den_reg   <= aou_pkg::fp_add(sq_root, epsilon_reg);
        ep_num_reg   <= sq_side[31:0];
        ep_carry_reg <= aou_pkg::carry_t'(sq_side[SQ_SIDE_W-1:32]);

        out_w_reg    <= aou_pkg::fp_canon(aou_pkg::fp_add(dv_carry.w, {~dv_quo[31], dv_quo[30:0]}));
        out_m_reg    <= aou_pkg::fp_canon(dv_carry.m);
        out_v_reg    <= aou_pkg::fp_canon(dv_carry.v);
        out_peak_reg <= dv_carry.peak;
    end

    aou_sqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .in_x      (s6_scaled_reg),
        .in_side   (s6_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    aou_div #(
        .SIDE_W (aou_pkg::CARRY_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ep_valid_reg),
        .in_num    (ep_num_reg),
        .in_den    (ep_den_reg),
        .in_side   (ep_carry_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    assign dv_carry = aou_pkg::carry_t'(dv_side);

    assign busy                   = 1'b0;
    assign cfg_ready              = 1'b1;
    assign done                   = out_valid_reg;
    assign new_weight             = out_w_reg;
    assign new_first_moment       = out_m_reg;
    assign new_second_moment      = out_v_reg;
    assign new_peak_second_moment = out_peak_reg;

endmodule
